// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: complex arithmetic unit shared types
// Word formats, operation codes and status codes for the complex ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int FIELD_W  = 32;
  localparam int TOL_W    = 16;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] a_re;
    logic signed [FIELD_W-1:0] a_im;
    logic signed [FIELD_W-1:0] b_re;
    logic signed [FIELD_W-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] result_re;
    logic signed [FIELD_W-1:0] result_im;
    logic                      compare_true;
    logic [STATUS_W-1:0]       status;
  } out_t;

  // per-word control that rides alongside the datapath
  typedef struct packed {
    logic [KIND_W-1:0]         op;
    logic signed [FIELD_W-1:0] res_re;
    logic signed [FIELD_W-1:0] res_im;
    logic                      cmp;
    logic                      sat;
    logic                      dz;
    logic                      neg_re;
    logic                      neg_im;
    logic                      ovf_re;
    logic                      ovf_im;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring-division step
// Resolves one quotient bit for the real and imaginary lanes and hands the
// partial remainders, quotients and divisor to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_cell #(
  parameter int RW    = 97,
  parameter int QW    = 33,
  parameter int DENW  = 64,
  parameter int SHIFT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire logic [DENW-1:0] den_in,
  input  wire logic [RW-1:0]   rre_in,
  input  wire logic [RW-1:0]   rim_in,
  input  wire logic [QW-1:0]   qre_in,
  input  wire logic [QW-1:0]   qim_in,
  output logic                 v_out,
  output logic [DENW-1:0]      den_out,
  output logic [RW-1:0]        rre_out,
  output logic [RW-1:0]        rim_out,
  output logic [QW-1:0]        qre_out,
  output logic [QW-1:0]        qim_out
);

  logic            v_r;
  logic [DENW-1:0] den_r;
  logic [RW-1:0]   rre_r, rim_r, rre_nxt, rim_nxt;
  logic [QW-1:0]   qre_r, qim_r, qre_nxt, qim_nxt;
  logic [RW-1:0]   dsh;
  logic            ge_re, ge_im;

  always_comb begin
    dsh     = RW'(den_in) << SHIFT;
    ge_re   = rre_in >= dsh;
    ge_im   = rim_in >= dsh;
    rre_nxt = ge_re ? (rre_in - dsh) : rre_in;
    rim_nxt = ge_im ? (rim_in - dsh) : rim_in;
    qre_nxt = {qre_in[QW-2:0], ge_re};
    qim_nxt = {qim_in[QW-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_in;
      rre_r <= rre_nxt;
      rim_r <= rim_nxt;
      qre_r <= qre_nxt;
      qim_r <= qim_nxt;
    end
  end

  assign v_out   = v_r;
  assign den_out = den_r;
  assign rre_out = rre_r;
  assign rim_out = rim_r;
  assign qre_out = qre_r;
  assign qim_out = qim_r;

endmodule

`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
// Every word, whatever FRAC_BITS is, passes through every stage from acceptance to
// result: decode, product combine, range check, one cell per quotient bit, output.
// Throughput: one word per cycle while the output is not stalled; the divider is a chain of one-bit cells.
// A stalled output only holds back words behind it once every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline and sets tolerance to 1.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex ALU, signed fixed point
// Add, subtract, multiply, divide and tolerance compare on complex operands.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire cau_pkg::in_t           in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output cau_pkg::out_t               out_data,
  input  wire logic                   cfg_we,
  input  wire logic [cau_pkg::TOL_W-1:0] cfg_wdata
);

  import cau_pkg::*;

  localparam int DW   = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int PW   = 2 * DW;
  localparam int QW   = DW + 1;
  localparam int RW   = PW + QW;
  localparam int CW   = RW + FRAC_BITS;
  localparam int NSTG = QW + 4;

  localparam logic [QW-1:0] LIM_POS = {2'b00, {(DW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(DW-1){1'b0}}};

  // clamp DW+1 bit value to DW bits, {sat, value}
  function automatic logic [DW:0] clamp_n(input logic [DW:0] v);
    logic ovf;
    ovf = v[DW] ^ v[DW-1];
    return ovf ? {1'b1, v[DW], {(DW-1){!v[DW]}}} : {1'b0, v[DW-1:0]};
  endfunction

  // clamp PW+1 bit value to DW bits, {sat, value}
  function automatic logic [DW:0] clamp_w(input logic [PW:0] v);
    logic fits;
    fits = (&v[PW:DW-1]) || !(|v[PW:DW-1]);
    return fits ? {1'b0, v[DW-1:0]} : {1'b1, v[PW], {(DW-1){!v[PW]}}};
  endfunction

  logic [TOL_W-1:0] tolerance_r;
  logic [NSTG-1:0]  vv;
  logic [NSTG-1:0]  en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= TOL_W'(1);
    end else if (cfg_we) begin
      tolerance_r <= cfg_wdata;
    end
  end

  // a stage may load when the output drains or it or any later stage is empty
  always_comb begin
    for (int j = 0; j < NSTG; j++) begin
      en[j] = out_ready || !(&(vv | ({NSTG{1'b1}} >> (NSTG - j))));
    end
  end

  assign in_ready = en[0];

  // ---------------- stage 1: operand decode, products, add/sub/compare
  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [DW:0]   s_re, s_im, d_re, d_im;
  logic [DW:0]          m_re, m_im, c_re, c_im;
  logic                 eq;
  side_t                s1_nxt, s1_r;
  logic                 v1_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_br_r, p_bi_r;

  assign ar = in_data.a_re[DW-1:0];
  assign ai = in_data.a_im[DW-1:0];
  assign br = in_data.b_re[DW-1:0];
  assign bi = in_data.b_im[DW-1:0];

  always_comb begin
    s_re   = ar + br;
    s_im   = ai + bi;
    d_re   = ar - br;
    d_im   = ai - bi;
    m_re   = d_re[DW] ? (-d_re) : d_re;
    m_im   = d_im[DW] ? (-d_im) : d_im;
    eq     = (m_re < (DW+1)'(tolerance_r)) && (m_im < (DW+1)'(tolerance_r));
    c_re   = '0;
    c_im   = '0;
    s1_nxt = '0;
    s1_nxt.op = in_data.kind;
    case (in_data.kind)
      OP_ADD: begin
        c_re = clamp_n(s_re);
        c_im = clamp_n(s_im);
        s1_nxt.res_re = signed'(c_re[DW-1:0]);
        s1_nxt.res_im = signed'(c_im[DW-1:0]);
        s1_nxt.sat    = c_re[DW] | c_im[DW];
      end
      OP_SUB: begin
        c_re = clamp_n(d_re);
        c_im = clamp_n(d_im);
        s1_nxt.res_re = signed'(c_re[DW-1:0]);
        s1_nxt.res_im = signed'(c_im[DW-1:0]);
        s1_nxt.sat    = c_re[DW] | c_im[DW];
      end
      OP_EQ:   s1_nxt.cmp = eq;
      OP_NE:   s1_nxt.cmp = !eq;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en[0]) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r   <= s1_nxt;
      p_rr_r <= ar * br;
      p_ii_r <= ai * bi;
      p_ir_r <= ai * br;
      p_ri_r <= ar * bi;
      p_br_r <= br * br;
      p_bi_r <= bi * bi;
    end
  end

  // ---------------- stage 2: product combine, divider operands
  logic signed [PW:0] mre, mim, nre, nim;
  logic [PW-1:0]      mim_w;
  logic [PW:0]        nre_abs, nim_abs;
  logic [DW:0]        cm_re, cm_im;
  logic [PW-1:0]      den;
  side_t              s2_nxt, s2_r;
  logic               v2_r;
  logic [PW-1:0]      mag_re_r, mag_im_r, den_r;

  always_comb begin
    mre     = p_rr_r - p_ii_r;
    // imaginary product sum wraps at the product width
    mim_w   = p_ir_r + p_ri_r;
    mim     = signed'({mim_w[PW-1], mim_w});
    nre     = p_rr_r + p_ii_r;
    nim     = p_ir_r - p_ri_r;
    nre_abs = nre[PW] ? (-nre) : nre;
    nim_abs = nim[PW] ? (-nim) : nim;
    den     = p_br_r + p_bi_r;
    cm_re   = clamp_w(mre >>> FRAC_BITS);
    cm_im   = clamp_w(mim >>> FRAC_BITS);
    s2_nxt  = s1_r;
    s2_nxt.neg_re = nre[PW];
    s2_nxt.neg_im = nim[PW];
    s2_nxt.dz     = (den == '0) ||
                    (CW'(den) < (CW'(tolerance_r) << FRAC_BITS));
    if (s1_r.op == OP_MUL) begin
      s2_nxt.res_re = signed'(cm_re[DW-1:0]);
      s2_nxt.res_im = signed'(cm_im[DW-1:0]);
      s2_nxt.sat    = cm_re[DW] | cm_im[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en[1]) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_r     <= s2_nxt;
      mag_re_r <= nre_abs[PW-1:0];
      mag_im_r <= nim_abs[PW-1:0];
      den_r    <= den;
    end
  end

  // ---------------- stage 3: quotient range check, remainder seed
  logic [CW-1:0] nw_re, nw_im, dw_sh;
  side_t         s3_nxt;
  side_t         side_p [QW+1];
  logic          c_v    [QW+1];
  logic [PW-1:0] c_den  [QW+1];
  logic [RW-1:0] c_rre  [QW+1];
  logic [RW-1:0] c_rim  [QW+1];
  logic [QW-1:0] c_qre  [QW+1];
  logic [QW-1:0] c_qim  [QW+1];
  logic          v3_r;
  logic [PW-1:0] den3_r;
  logic [RW-1:0] rre3_r, rim3_r;

  always_comb begin
    nw_re  = CW'(mag_re_r) << FRAC_BITS;
    nw_im  = CW'(mag_im_r) << FRAC_BITS;
    dw_sh  = CW'(den_r) << QW;
    s3_nxt = s2_r;
    s3_nxt.ovf_re = nw_re >= dw_sh;
    s3_nxt.ovf_im = nw_im >= dw_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en[2]) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_p[0] <= s3_nxt;
      den3_r    <= den_r;
      rre3_r    <= nw_re[RW-1:0];
      rim3_r    <= nw_im[RW-1:0];
    end
  end

  assign c_v[0]   = v3_r;
  assign c_den[0] = den3_r;
  assign c_rre[0] = rre3_r;
  assign c_rim[0] = rim3_r;
  assign c_qre[0] = '0;
  assign c_qim[0] = '0;

  // ---------------- divider chain, one quotient bit per cell
  for (genvar k = 0; k < QW; k++) begin : g_div
    cau_div_cell #(
      .RW    (RW),
      .QW    (QW),
      .DENW  (PW),
      .SHIFT (QW - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[k+3]),
      .v_in    (c_v[k]),
      .den_in  (c_den[k]),
      .rre_in  (c_rre[k]),
      .rim_in  (c_rim[k]),
      .qre_in  (c_qre[k]),
      .qim_in  (c_qim[k]),
      .v_out   (c_v[k+1]),
      .den_out (c_den[k+1]),
      .rre_out (c_rre[k+1]),
      .rim_out (c_rim[k+1]),
      .qre_out (c_qre[k+1]),
      .qim_out (c_qim[k+1])
    );

    always_ff @(posedge clk) begin
      if (en[k+3]) begin
        side_p[k+1] <= side_p[k];
      end
    end
  end

  // ---------------- output stage
  side_t         sf;
  logic [QW-1:0] lim_re, lim_im, qv_re, qv_im, sq_re, sq_im;
  logic          qs_re, qs_im;
  out_t          out_nxt, out_data_r;
  logic          out_valid_r;

  always_comb begin
    sf     = side_p[QW];
    lim_re = sf.neg_re ? LIM_NEG : LIM_POS;
    lim_im = sf.neg_im ? LIM_NEG : LIM_POS;
    qs_re  = sf.ovf_re || (c_qre[QW] > lim_re);
    qs_im  = sf.ovf_im || (c_qim[QW] > lim_im);
    qv_re  = qs_re ? lim_re : c_qre[QW];
    qv_im  = qs_im ? lim_im : c_qim[QW];
    sq_re  = sf.neg_re ? (-qv_re) : qv_re;
    sq_im  = sf.neg_im ? (-qv_im) : qv_im;
    out_nxt = '0;
    out_nxt.compare_true = sf.cmp;
    case (sf.op)
      OP_DIV: begin
        if (sf.dz) begin
          out_nxt.status = ST_DIVZ;
        end else begin
          out_nxt.result_re = signed'(sq_re[DW-1:0]);
          out_nxt.result_im = signed'(sq_im[DW-1:0]);
          out_nxt.status    = (qs_re || qs_im) ? ST_SAT : ST_OK;
        end
      end
      default: begin
        out_nxt.result_re = sf.res_re;
        out_nxt.result_im = sf.res_im;
        out_nxt.status    = sf.sat ? ST_SAT : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[NSTG-1]) begin
      out_valid_r <= c_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    vv[0] = v1_r;
    vv[1] = v2_r;
    for (int j = 0; j <= QW; j++) begin
      vv[j+2] = c_v[j];
    end
    vv[NSTG-1] = out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex ALU
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire cau_pkg::out_t out_data
);

  import cau_pkg::*;

  // a waiting word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // divisor near zero gives a zero quotient
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DIVZ |->
      out_data.result_re == '0 && out_data.result_im == '0 && !out_data.compare_true)
    else $error("nonzero result with divide-by-zero status");

  // words with the compare flag set carry no result and a clean status
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.compare_true |->
      out_data.status == ST_OK && out_data.result_re == '0 && out_data.result_im == '0)
    else $error("compare word with nonzero payload");

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_DIVZ ||
                  out_data.status == ST_SAT)
    else $error("undefined status code");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: complex arithmetic unit testbench
// Drives operation words through a valid/ready stream with bursty gaps
// and a stalling receiver, and scores every result against a local model.
// The model covers saturation, near-zero divisors and tolerance compares.
// The tolerance register is swept across phases, idle between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 45;
  localparam int PHASE_ITEMS  = 390;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;
  logic            cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  in_t             pending_words[$];
  out_t            expected_results[$];
  logic [TOL_W-1:0] tolerance_q = 16'd1;
  int              error_count = 0;
  int              result_count = 0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              cycle_count = 0;

  always #1 clk = ~clk;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic longint clamp_data(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // truncated quotient with 16 fraction bits; num is a wrapped 64-bit pattern
  function automatic longint quotient_part(logic [63:0] num, logic [63:0] den,
                                           inout logic sat);
    logic        neg;
    logic [63:0] mag;
    logic [79:0] q;
    logic [79:0] limit;
    neg = num[63] && (num != 64'h8000_0000_0000_0000);
    mag = neg ? -num : num;
    limit = neg ? 80'h8000_0000 : 80'h7fff_ffff;
    q = {mag, 16'h0} / {16'h0, den};
    if (q > limit) begin
      sat = 1'b1;
      q = limit;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic out_t complex_result(in_t w, logic [TOL_W-1:0] tol);
    longint      ar, ai, br, bi, re, im, dr, di;
    logic [63:0] den, mr, mi;
    logic        sat, eq;
    out_t        r;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    re = 0; im = 0; sat = 1'b0;
    r = '0;
    case (w.kind)
      OP_ADD: begin
        re = clamp_data(ar + br, sat);
        im = clamp_data(ai + bi, sat);
      end
      OP_SUB: begin
        re = clamp_data(ar - br, sat);
        im = clamp_data(ai - bi, sat);
      end
      OP_MUL: begin
        re = clamp_data((ar * br - ai * bi) >>> 16, sat);
        im = clamp_data((ar * bi + ai * br) >>> 16, sat);
      end
      OP_DIV: begin
        den = ar * 0 + br * br + bi * bi;
        if (den == 0 || den < ({48'h0, tol} << 16)) begin
          r.status = ST_DIVZ;
        end else begin
          re = quotient_part(ar * br + ai * bi, den, sat);
          im = quotient_part(ai * br - ar * bi, den, sat);
        end
      end
      OP_EQ, OP_NE: begin
        dr = ar - br;
        di = ai - bi;
        mr = dr < 0 ? -dr : dr;
        mi = di < 0 ? -di : di;
        eq = (mr < tol) && (mi < tol);
        r.compare_true = (w.kind == OP_EQ) ? eq : !eq;
      end
      default: ;
    endcase
    if (sat && r.status == ST_OK) r.status = ST_SAT;
    r.result_re = re[31:0];
    r.result_im = im[31:0];
    return r;
  endfunction

  // driver: bursts of words separated by random gaps
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_ready)
      expected_results.push_back(complex_result(in_data, tolerance_q));
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls: quiet stretches alternate with random back-pressure
  always @(posedge clk) begin
    if (cycle_count[9:8] == 2'd0)
      out_ready <= 1'b1;
    else if (cycle_count[9:8] == 2'd1)
      out_ready <= ($urandom_range(0, 7) == 0);
    else
      out_ready <= ($urandom_range(0, 2) != 0);
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      result_count <= result_count + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count <= error_count + 1;
      end else begin
        exp_word = expected_results.pop_front();
        if (out_data.result_re !== exp_word.result_re ||
            out_data.result_im !== exp_word.result_im ||
            out_data.compare_true !== exp_word.compare_true ||
            out_data.status !== exp_word.status) begin
          $display("%0t: mismatch re exp %h got %h, im exp %h got %h", $time,
                   exp_word.result_re, out_data.result_re,
                   exp_word.result_im, out_data.result_im);
          $display("%0t:          cmp exp %b got %b, status exp %0d got %0d", $time,
                   exp_word.compare_true, out_data.compare_true,
                   exp_word.status, out_data.status);
          error_count <= error_count + 1;
        end
      end
    end
  end

  function automatic logic [31:0] pick_value(logic [31:0] near);
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 65536 * 8))) - 32'd262144;
      3, 4: return 32'($urandom_range(0, 32'h0003_ffff)) - 32'h0001_ffff;
      5: return near + 32'($urandom_range(0, 4)) - 32'd2;
      6: return near + 32'($urandom_range(0, 131070)) - 32'd65535;
      7: return 32'($urandom_range(0, 600)) - 32'd300;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_word(logic [KIND_W-1:0] kind, logic [31:0] ar,
                                    logic [31:0] ai, logic [31:0] br, logic [31:0] bi);
    in_t w;
    w.kind = kind; w.a_re = ar; w.a_im = ai; w.b_re = br; w.b_im = bi;
    return w;
  endfunction

  task automatic queue_random(int n);
    in_t w;
    repeat (n) begin
      w.kind = ($urandom_range(0, 19) == 0) ? KIND_W'($urandom_range(6, 7))
                                            : KIND_W'($urandom_range(0, 5));
      w.a_re = pick_value(32'h0);
      w.a_im = pick_value(32'h0);
      w.b_re = pick_value(w.a_re);
      w.b_im = pick_value(w.a_im);
      pending_words.push_back(w);
    end
  endtask

  task automatic wait_idle;
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tolerance_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [TOL_W-1:0] tol_list[5];
    tol_list = '{16'd1, 16'd65535, 16'd256, 16'd1, 16'd1};
    tol_list[3] = $urandom_range(2, 65534);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      write_tolerance(tol_list[p]);
      if (p == 0) begin
        pending_words.push_back(make_word(OP_ADD, 32'h7fff_ffff, 32'h8000_0000,
                                          32'h1, 32'hffff_ffff));
        pending_words.push_back(make_word(OP_ADD, 32'h1234_5678, 32'hedcb_a988,
                                          32'h0001_0000, 32'h0));
        pending_words.push_back(make_word(OP_SUB, 32'h8000_0000, 32'h7fff_ffff,
                                          32'h1, 32'hffff_ffff));
        pending_words.push_back(make_word(OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_8000,
                                          32'h0002_0000));
        pending_words.push_back(make_word(OP_MUL, 32'h0002_0000, 32'h0003_0000,
                                          32'hffff_0000, 32'h0000_8000));
        pending_words.push_back(make_word(OP_MUL, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(make_word(OP_MUL, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                                          32'h0));
        pending_words.push_back(make_word(OP_MUL, 32'hffff_ffff, 32'h1, 32'h1, 32'h1));
        pending_words.push_back(make_word(OP_DIV, 32'h0001_0000, 32'h0001_0000,
                                          32'h0, 32'h0));
        pending_words.push_back(make_word(OP_DIV, 32'h0005_0000, 32'h0, 32'h0, 32'h1));
        pending_words.push_back(make_word(OP_DIV, 32'h0005_0000, 32'hfffd_0000,
                                          32'h0002_0000, 32'h0001_0000));
        pending_words.push_back(make_word(OP_DIV, 32'h7fff_ffff, 32'h8000_0000,
                                          32'h0000_0100, 32'h0));
        pending_words.push_back(make_word(OP_DIV, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(make_word(OP_DIV, 32'hffff_ffff, 32'h1, 32'h0003_0000,
                                          32'hfffe_0000));
        pending_words.push_back(make_word(OP_EQ, 32'h0001_0000, 32'h2, 32'h0001_0000,
                                          32'h2));
        pending_words.push_back(make_word(OP_EQ, 32'h0001_0000, 32'h2, 32'h0001_0001,
                                          32'h2));
        pending_words.push_back(make_word(OP_NE, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
                                          32'h0));
        pending_words.push_back(make_word(OP_NE, 32'h5, 32'h6, 32'h5, 32'h6));
        pending_words.push_back(make_word(3'd6, 32'h1, 32'h2, 32'h3, 32'h4));
        pending_words.push_back(make_word(3'd7, 32'hffff_ffff, 32'hffff_ffff,
                                          32'hffff_ffff, 32'hffff_ffff));
      end
      queue_random(PHASE_ITEMS);
      wait_idle();
    end
    if (expected_results.size() != 0) error_count++;
    $display("Covered %0d results over five tolerance settings incl. 1 and 65535,", result_count);
    $display("with all six operations, unused codes, saturation and near-zero divisors.");
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
